// ===== hw/rtl/mpl_pkg.sv =====
`default_nettype none
package mpl_pkg;

    localparam int MAX_PHASES = 8;
    localparam int IW = $clog2(MAX_PHASES);
    localparam int CW = $clog2(MAX_PHASES + 1);

    localparam int DW = 32;   // diameter
    localparam int FW = 17;   // q1.16 fraction
    localparam int LW = 16;   // phase packing limit
    localparam int RAM_W = DW + FW + LW + FW;
    localparam int SUM_W = FW + $clog2(MAX_PHASES);

    localparam logic [16:0] ONE    = 17'd65536;
    localparam logic [17:0] TWO    = 18'd131072;
    localparam logic [16:0] CUTOFF = 17'd48562;   // 0.741
    localparam logic [17:0] K235   = 18'd154010;  // 2.35
    localparam logic [16:0] K135   = 17'd88474;   // 1.35

    localparam int CFG_IW = 2;
    localparam logic [CFG_IW-1:0] CFG_MIX_RES   = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_MIN_PL    = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_RATIO_TOL = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE, OP_INIT, OP_LAT_I, OP_LAT_J, OP_SET_R, OP_MUL1, OP_MUL2,
        OP_SET_Q, OP_MUL3, OP_SET_P, OP_SET_M, OP_M_ZERO, OP_SET_C, OP_MUL4,
        OP_ACC, OP_BEST, OP_FIN
    } t_op;

    typedef enum logic [2:0] {
        DV_R, DV_Q, DV_M, DV_C, DV_S, DV_CAND
    } t_dsel;

    typedef struct packed {
        t_op           op;
        logic          div_go;
        t_dsel         dsel;
        logic          load;
        logic          take;
        logic [CW-1:0] n;
        logic [CW-1:0] pos;
        logic          gt;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic dilute;
        logic i_pres;
        logic j_pres;
        logic tol_skip;
        logic p_pos;
        logic sum_lt;
    } t_stat;

endpackage
`default_nettype wire

// ===== hw/rtl/multiphase_packing_limit_unit.sv =====
// channel   | direction | handshake              | payload
// phase in  | in        | start & !busy          | i_diameter .. i_last_phase
// result    | out       | o_strobe, one cycle    | o_packing_limit, o_dilute
// config    | in        | i_cfg_valid & ready    | i_cfg_index, i_cfg_data
//
// a phase without last_phase is stored (up to eight a cell), busy stays low
// the last phase of a cell starts the pair walk: per present pair of phases
// one transfer through the shared divider for the diameter ratio and, unless
// the ratio is within tolerance, three or four more plus multiply steps, and
// one more division per present phase whose sum is below one
// a dilute cell skips the pair walk; busy covers the whole computation
// synchronous active-low reset; no clearing pass, results are never stalled
`default_nettype none
module multiphase_packing_limit_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // phase input
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [31:0]                i_diameter,
    input  wire logic [16:0]                i_phase_fraction,
    input  wire logic [15:0]                i_phase_max_fraction,
    input  wire logic [16:0]                i_phase_residual,
    input  wire logic [16:0]                i_total_fraction,
    input  wire logic                       i_keep_order,
    input  wire logic                       i_last_phase,
    // result
    output logic                            o_strobe,
    output logic [16:0]                     o_packing_limit,
    output logic                            o_dilute,
    // configuration writes
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [mpl_pkg::CFG_IW-1:0] i_cfg_index,
    input  wire logic [16:0]                i_cfg_data
);
    import mpl_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // the user must write registers only while idle; nothing in the unit enforces it, so a write is always taken
    assign o_cfg_ready = 1'b1;

    // sequencer: phase count, pair loop counters, divider and multiply steps
    mpl_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_last_phase (i_last_phase),
        .i_stat       (stat),
        .o_cmd        (cmd),
        .o_busy       (busy),
        .o_strobe     (o_strobe)
    );

    // phase store, diameter ranking, arithmetic and result registers
    mpl_dpath u_dpath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_stat               (stat),
        .i_diameter           (i_diameter),
        .i_phase_fraction     (i_phase_fraction),
        .i_phase_max_fraction (i_phase_max_fraction),
        .i_phase_residual     (i_phase_residual),
        .i_total_fraction     (i_total_fraction),
        .i_keep_order         (i_keep_order),
        .i_cfg_we             (i_cfg_valid && o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .o_packing_limit      (o_packing_limit),
        .o_dilute             (o_dilute)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/mpl_ram.sv =====
`default_nettype none
module mpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/mpl_div.sv =====
`default_nettype none
module mpl_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_go,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic             o_done,
    output logic [16:0]      o_q
);
    import mpl_pkg::*;

    logic        r_run;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_b;
    logic        r_a0;
    logic [32:0] shifted;
    logic        qbit;
    logic [16:0] n_q;

    // one quotient bit per cycle, quotient below 2^17 once a < 2b
    always_comb begin
        shifted = {r_rem, (r_cnt == 5'd16) ? r_a0 : 1'b0};
        qbit    = (shifted >= {1'b0, r_b});
        n_q     = {o_q[15:0], qbit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_go) begin
                if (i_a == 32'd0) begin
                    o_q    <= 17'd0;
                    o_done <= 1'b1;
                end else if ({1'b0, i_a} >= {i_b, 1'b0}) begin
                    o_q    <= ONE;
                    o_done <= 1'b1;
                end else begin
                    r_run <= 1'b1;
                    r_rem <= {1'b0, i_a[31:1]};
                    r_a0  <= i_a[0];
                    r_b   <= i_b;
                    r_cnt <= 5'd16;
                    o_q   <= 17'd0;
                end
            end else if (r_run) begin
                r_rem <= qbit ? 32'(shifted - {1'b0, r_b}) : shifted[31:0];
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_run  <= 1'b0;
                    o_done <= 1'b1;
                    o_q    <= (n_q > ONE) ? ONE : n_q;
                end else begin
                    o_q <= n_q;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/mpl_dpath.sv =====
`default_nettype none
module mpl_dpath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire mpl_pkg::t_cmd                 i_cmd,
    output mpl_pkg::t_stat                     o_stat,
    input  wire logic [31:0]                   i_diameter,
    input  wire logic [16:0]                   i_phase_fraction,
    input  wire logic [15:0]                   i_phase_max_fraction,
    input  wire logic [16:0]                   i_phase_residual,
    input  wire logic [16:0]                   i_total_fraction,
    input  wire logic                          i_keep_order,
    input  wire logic                          i_cfg_we,
    input  wire logic [mpl_pkg::CFG_IW-1:0]    i_cfg_index,
    input  wire logic [16:0]                   i_cfg_data,
    output logic [16:0]                        o_packing_limit,
    output logic                               o_dilute
);
    import mpl_pkg::*;

    // rank table for the falling-diameter order, built as phases arrive
    logic [DW-1:0] r_dstore [MAX_PHASES];
    logic [IW-1:0] r_rank   [MAX_PHASES];

    logic [16:0] r_mres, r_minpl, r_tol;
    logic [16:0] r_total, r_cden;
    logic        r_keep;

    logic [LW-1:0] r_a1;
    logic [DW-1:0] r_d1, r_d2;
    logic [16:0]   r_fj;
    logic          r_ipres, r_jpres;

    logic [16:0]        r_r, r_x, r_m, r_cx, r_mcx, r_best;
    logic [33:0]        r_rr;
    logic [34:0]        r_k235;
    logic [48:0]        r_k135;
    logic [32:0]        r_w;
    logic signed [19:0] r_poly;
    logic signed [53:0] r_wp;
    logic signed [20:0] r_p;
    logic [SUM_W-1:0]   r_sum;

    logic [RAM_W-1:0] rdata;
    logic [IW-1:0]    rd_idx;
    logic [CW-1:0]    ge_cnt;
    logic [31:0]      div_a, div_b;
    logic             div_done;
    logic [16:0]      dq;

    logic signed [36:0] poly32, poly_mag;
    logic signed [19:0] poly16;
    logic signed [53:0] wp_mag;
    logic signed [20:0] delta;
    logic [33:0]        mcx_full;
    logic [16:0]        cand;
    logic               cut;

    wire [DW-1:0] rd_d   = rdata[RAM_W-1 -: DW];
    wire [FW-1:0] rd_f   = rdata[FW+LW+FW-1 -: FW];
    wire [LW-1:0] rd_a   = rdata[LW+FW-1 -: LW];
    wire [FW-1:0] rd_res = rdata[FW-1:0];

    mpl_ram #(.WIDTH(RAM_W), .DEPTH(MAX_PHASES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (i_cmd.n[IW-1:0]),
        .i_wdata ({i_diameter, i_phase_fraction, i_phase_max_fraction, i_phase_residual}),
        .i_raddr (rd_idx),
        .o_rdata (rdata)
    );

    mpl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.div_go),
        .i_a     (div_a),
        .i_b     (div_b),
        .o_done  (div_done),
        .o_q     (dq)
    );

    // sorted position to store entry, or the position itself when the order is kept
    always_comb begin
        rd_idx = i_cmd.pos[IW-1:0];
        if (!r_keep) begin
            rd_idx = '0;
            for (int k = 0; k < MAX_PHASES; k++) begin
                if (CW'(k) < i_cmd.n && r_rank[k] == i_cmd.pos[IW-1:0]) begin
                    rd_idx = IW'(k);
                end
            end
        end
    end

    // new phase goes after all stored ones at least as large
    always_comb begin
        ge_cnt = '0;
        for (int k = 0; k < MAX_PHASES; k++) begin
            if (CW'(k) < i_cmd.n && r_dstore[k] >= i_diameter) begin
                ge_cnt = ge_cnt + 1'b1;
            end
        end
    end

    always_comb begin
        div_a = 32'd0;
        div_b = 32'd0;
        case (i_cmd.dsel)
            DV_R: begin
                div_a = i_cmd.gt ? r_d1 : r_d2;
                div_b = i_cmd.gt ? r_d2 : r_d1;
            end
            DV_Q: begin
                div_a = 32'(ONE - r_rr[32:16]);
                div_b = 32'(TWO - {2'b0, r_a1});
            end
            DV_M: begin
                div_a = 32'(r_a1);
                div_b = 32'(unsigned'(r_p));
            end
            DV_C: begin
                div_a = 32'(r_fj);
                div_b = 32'(r_cden);
            end
            DV_S: begin
                div_a = 32'(r_mcx);
                div_b = 32'(r_x);
            end
            DV_CAND: begin
                div_a = 32'(r_a1);
                div_b = 32'(ONE - r_sum[16:0]);
            end
            default: begin
                div_a = 32'd0;
                div_b = 32'd0;
            end
        endcase
    end

    // 1 - 2.35 r + 1.35 r^2, then the packing correction term, both truncated toward zero
    always_comb begin
        poly32   = 37'sd4294967296 - $signed({2'b0, r_k235}) + $signed({4'b0, r_k135[48:16]});
        poly_mag = (poly32 < 0) ? -poly32 : poly32;
        poly16   = (poly32 < 0) ? -20'(poly_mag >>> 16) : 20'(poly_mag >>> 16);
        wp_mag   = (r_wp < 0) ? -r_wp : r_wp;
        delta    = (r_wp < 0) ? -21'(wp_mag >>> 32) : 21'(wp_mag >>> 32);
        cut      = (r_r <= CUTOFF);
        mcx_full = {17'b0, r_m} * {17'b0, r_cx};
        cand     = r_sum < SUM_W'(ONE) ? dq : ((r_sum == SUM_W'(ONE)) ? ONE : 17'd0);
    end

    always_comb begin
        o_stat.div_done = div_done;
        o_stat.dilute   = (r_total < r_mres);
        o_stat.i_pres   = r_ipres;
        o_stat.j_pres   = r_jpres;
        o_stat.tol_skip = ((ONE - r_r) <= r_tol);
        o_stat.p_pos    = (r_p > 21'sd0);
        o_stat.sum_lt   = (r_sum < SUM_W'(ONE));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mres  <= 17'd1;
            r_minpl <= 17'd32768;
            r_tol   <= 17'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MIX_RES:   r_mres  <= i_cfg_data;
                CFG_MIN_PL:    r_minpl <= i_cfg_data;
                CFG_RATIO_TOL: r_tol   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_total <= i_total_fraction;
            r_keep  <= i_keep_order;
        end
        if (i_cmd.load) begin
            for (int k = 0; k < MAX_PHASES; k++) begin
                if (CW'(k) < i_cmd.n && r_dstore[k] < i_diameter) begin
                    r_rank[k] <= r_rank[k] + 1'b1;
                end
            end
            r_rank[i_cmd.n[IW-1:0]]   <= ge_cnt[IW-1:0];
            r_dstore[i_cmd.n[IW-1:0]] <= i_diameter;
        end

        case (i_cmd.op)
            OP_INIT: begin
                r_cden <= (r_total > r_mres) ? r_total : r_mres;
                r_best <= ONE;
            end
            OP_LAT_I: begin
                r_a1    <= rd_a;
                r_d1    <= rd_d;
                r_ipres <= (rd_f >= rd_res);
                r_sum   <= '0;
            end
            OP_LAT_J: begin
                r_d2    <= rd_d;
                r_fj    <= rd_f;
                r_jpres <= (rd_f >= rd_res);
            end
            OP_SET_R: r_r <= dq;
            OP_MUL1: begin
                r_rr   <= {17'b0, r_r} * {17'b0, r_r};
                r_k235 <= {17'b0, K235} * {18'b0, r_r};
            end
            OP_MUL2: begin
                r_k135 <= {32'b0, K135} * {17'b0, r_rr[31:0]};
                r_w    <= {17'b0, r_a1} * {16'b0, ONE - {1'b0, r_a1}};
            end
            OP_SET_Q: begin
                r_x    <= i_cmd.gt ? dq : ONE - dq;
                r_poly <= poly16;
            end
            OP_MUL3:   r_wp <= $signed({1'b0, r_w}) * r_poly;
            OP_SET_P:  r_p  <= $signed({5'b0, r_a1}) + (cut ? delta : 21'sd0);
            OP_SET_M:  r_m  <= ONE - dq;
            OP_M_ZERO: r_m  <= 17'd0;
            OP_SET_C:  r_cx <= dq;
            OP_MUL4:   r_mcx <= mcx_full[32:16];
            OP_ACC:    r_sum <= r_sum + SUM_W'(dq);
            OP_BEST: begin
                if (cand < r_best) begin
                    r_best <= cand;
                end
            end
            OP_FIN: begin
                o_dilute <= o_stat.dilute;
                if (o_stat.dilute || r_best <= r_minpl) begin
                    o_packing_limit <= r_minpl;
                end else begin
                    o_packing_limit <= r_best;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== hw/rtl/mpl_ctrl.sv =====
`default_nettype none
module mpl_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic           i_last_phase,
    input  wire mpl_pkg::t_stat i_stat,
    output mpl_pkg::t_cmd       o_cmd,
    output logic                o_busy,
    output logic                o_strobe
);
    import mpl_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE, S_INIT, S_IRD, S_ILAT, S_ICHK, S_JTOP, S_JLAT, S_JCHK,
        S_RW, S_RSET, S_RCHK, S_MUL2, S_QW, S_QSET, S_MUL3, S_PSET, S_PCHK,
        S_MW, S_MSET, S_CDIV, S_CW, S_CSET, S_MUL4, S_SDIV, S_SW, S_ACC,
        S_JNEXT, S_CAND, S_KW, S_BEST, S_INEXT, S_FIN, S_OUT
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count, r_ii, n_ii, r_jj, n_jj;
    logic          accept;

    assign accept = i_start && !o_busy;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ii         = r_ii;
        n_jj         = r_jj;
        o_cmd.op     = OP_NONE;
        o_cmd.div_go = 1'b0;
        o_cmd.dsel   = DV_R;
        o_cmd.take   = accept;
        o_cmd.load   = accept && (r_count < CW'(MAX_PHASES));
        o_cmd.n      = r_count;
        o_cmd.pos    = r_jj;
        o_cmd.gt     = (r_ii > r_jj);
        if (o_cmd.load) begin
            n_count = r_count + 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                if (accept && i_last_phase) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.op = OP_INIT;
                n_ii     = '0;
                if (i_stat.dilute || r_count == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_IRD;
                end
            end
            S_IRD: begin
                o_cmd.pos = r_ii;
                n_state   = S_ILAT;
            end
            S_ILAT: begin
                o_cmd.op = OP_LAT_I;
                n_state  = S_ICHK;
            end
            S_ICHK: begin
                n_jj    = '0;
                n_state = i_stat.i_pres ? S_JTOP : S_INEXT;
            end
            S_JTOP:  n_state = (r_jj == r_ii) ? S_JNEXT : S_JLAT;
            S_JLAT: begin
                o_cmd.op = OP_LAT_J;
                n_state  = S_JCHK;
            end
            S_JCHK: begin
                if (i_stat.j_pres) begin
                    o_cmd.div_go = 1'b1;
                    o_cmd.dsel   = DV_R;
                    n_state      = S_RW;
                end else begin
                    n_state = S_JNEXT;
                end
            end
            S_RW:    n_state = i_stat.div_done ? S_RSET : S_RW;
            S_RSET: begin
                o_cmd.op = OP_SET_R;
                n_state  = S_RCHK;
            end
            S_RCHK: begin
                if (i_stat.tol_skip) begin
                    n_state = S_JNEXT;
                end else begin
                    o_cmd.op = OP_MUL1;
                    n_state  = S_MUL2;
                end
            end
            S_MUL2: begin
                o_cmd.op     = OP_MUL2;
                o_cmd.div_go = 1'b1;
                o_cmd.dsel   = DV_Q;
                n_state      = S_QW;
            end
            S_QW:    n_state = i_stat.div_done ? S_QSET : S_QW;
            S_QSET: begin
                o_cmd.op = OP_SET_Q;
                n_state  = S_MUL3;
            end
            S_MUL3: begin
                o_cmd.op = OP_MUL3;
                n_state  = S_PSET;
            end
            S_PSET: begin
                o_cmd.op = OP_SET_P;
                n_state  = S_PCHK;
            end
            S_PCHK: begin
                if (i_stat.p_pos) begin
                    o_cmd.div_go = 1'b1;
                    o_cmd.dsel   = DV_M;
                    n_state      = S_MW;
                end else begin
                    o_cmd.op = OP_M_ZERO;
                    n_state  = S_CDIV;
                end
            end
            S_MW:    n_state = i_stat.div_done ? S_MSET : S_MW;
            S_MSET: begin
                o_cmd.op = OP_SET_M;
                n_state  = S_CDIV;
            end
            S_CDIV: begin
                o_cmd.div_go = 1'b1;
                o_cmd.dsel   = DV_C;
                n_state      = S_CW;
            end
            S_CW:    n_state = i_stat.div_done ? S_CSET : S_CW;
            S_CSET: begin
                o_cmd.op = OP_SET_C;
                n_state  = S_MUL4;
            end
            S_MUL4: begin
                o_cmd.op = OP_MUL4;
                n_state  = S_SDIV;
            end
            S_SDIV: begin
                o_cmd.div_go = 1'b1;
                o_cmd.dsel   = DV_S;
                n_state      = S_SW;
            end
            S_SW:    n_state = i_stat.div_done ? S_ACC : S_SW;
            S_ACC: begin
                o_cmd.op = OP_ACC;
                n_state  = S_JNEXT;
            end
            S_JNEXT: begin
                n_jj    = r_jj + 1'b1;
                n_state = (n_jj == r_count) ? S_CAND : S_JTOP;
            end
            S_CAND: begin
                if (i_stat.sum_lt) begin
                    o_cmd.div_go = 1'b1;
                    o_cmd.dsel   = DV_CAND;
                    n_state      = S_KW;
                end else begin
                    n_state = S_BEST;
                end
            end
            S_KW:    n_state = i_stat.div_done ? S_BEST : S_KW;
            S_BEST: begin
                o_cmd.op = OP_BEST;
                n_state  = S_INEXT;
            end
            S_INEXT: begin
                n_ii    = r_ii + 1'b1;
                n_state = (n_ii == r_count) ? S_FIN : S_IRD;
            end
            S_FIN: begin
                o_cmd.op = OP_FIN;
                n_state  = S_OUT;
            end
            S_OUT: begin
                n_count = '0;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ii     <= '0;
            r_jj     <= '0;
            o_busy   <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ii     <= n_ii;
            r_jj     <= n_jj;
            o_busy   <= (n_state != S_IDLE);
            o_strobe <= (n_state == S_OUT);
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/mpl_checker.sv =====
`default_nettype none
module mpl_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic                       i_last_phase,
    input wire logic                       o_strobe,
    input wire logic [16:0]                o_packing_limit,
    input wire logic                       o_dilute
);
    // a non-final phase never makes the unit busy
    a_plain_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_last_phase) |=> !busy)
        else $error("busy after non-final phase");

    // the final phase always starts a computation
    a_last_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last_phase) |=> busy)
        else $error("final phase did not start computation");

    // a result only closes a computation
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result outside computation");

    // exactly one cycle per result
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result held longer than one cycle");

    // limit never exceeds one when computed
    a_limit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_dilute) |-> (o_packing_limit <= 17'd65536))
        else $error("packing limit above one");
endmodule

bind multiphase_packing_limit_unit mpl_checker u_mpl_checker (.*);
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import mpl_pkg::*;

    localparam int MAXN = 8;
    localparam logic [63:0] Q1 = 64'd65536;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    wire         busy;
    logic [31:0] i_diameter = '0;
    logic [16:0] i_phase_fraction = '0;
    logic [15:0] i_phase_max_fraction = 16'd1;
    logic [16:0] i_phase_residual = '0;
    logic [16:0] i_total_fraction = '0;
    logic        i_keep_order = 1'b0;
    logic        i_last_phase = 1'b0;
    wire         o_strobe;
    wire  [16:0] o_packing_limit;
    wire         o_dilute;
    logic        i_cfg_valid = 1'b0;
    wire         o_cfg_ready;
    logic [CFG_IW-1:0] i_cfg_index = CFG_MIX_RES;
    logic [16:0] i_cfg_data = '0;

    multiphase_packing_limit_unit uut (.*);

    always #4 i_clk = ~i_clk;

    // one phase as it arrives on the input ports
    typedef struct {
        logic [31:0] diam;
        logic [16:0] frac;
        logic [15:0] lim;
        logic [16:0] res;
        logic [16:0] total;
        logic        keep;
        logic        last;
    } phase_t;

    typedef struct {
        logic [16:0] limit;
        logic        dil;
    } cell_out_t;

    // predictor state: registers and stored phases of the open cell
    logic [63:0] mix_res = 1, min_pl = 32768, tol = 0;
    logic [63:0] st_diam[MAXN], st_frac[MAXN], st_lim[MAXN], st_res[MAXN];
    int unsigned n_stored = 0;

    cell_out_t expected_cells[$];
    int errors = 0, cells_checked = 0, phases_sent = 0, idle_cycles = 0;
    bit allow_gaps = 1;

    function automatic logic [63:0] qdiv(logic [63:0] a, logic [63:0] b);
        logic [63:0] q;
        if (a == 0) return 0;
        if (b == 0) return Q1;
        q = (a << 16) / b;
        return q > Q1 ? Q1 : q;
    endfunction

    // yu-standish pair walk over the stored phases
    function automatic logic [63:0] mixture_limit(logic [63:0] total, bit keep);
        int unsigned ord[MAXN];
        int unsigned a, b, cur;
        logic [63:0] best, cden, a1, d1, sum, cand, r, q, x, m, cx;
        longint p, poly32, poly16, w;
        best = Q1;
        cden = total > mix_res ? total : mix_res;
        for (a = 0; a < n_stored; a++) begin
            cur = a;
            b = a;
            if (!keep)
                while (b > 0 && st_diam[ord[b-1]] < st_diam[cur]) begin
                    ord[b] = ord[b-1];
                    b--;
                end
            ord[b] = cur;
        end
        for (a = 0; a < n_stored; a++) begin
            a1 = st_lim[ord[a]];
            d1 = st_diam[ord[a]];
            sum = 0;
            if (st_frac[ord[a]] < st_res[ord[a]]) continue;
            for (b = 0; b < n_stored; b++) begin
                if (b == a) continue;
                // absent partners are skipped too
                if (st_frac[ord[b]] < st_res[ord[b]]) continue;
                r = a > b ? qdiv(d1, st_diam[ord[b]]) : qdiv(st_diam[ord[b]], d1);
                if (Q1 - r <= tol) continue;
                q = qdiv(Q1 - ((r * r) >> 16), 2 * Q1 - a1);
                x = a > b ? q : Q1 - q;
                p = longint'(a1);
                if (r <= 48562) begin
                    poly32 = 64'sd4294967296 - 64'sd154010 * longint'(r)
                             + longint'((64'd88474 * r * r) >> 16);
                    poly16 = poly32 / 65536;
                    w = longint'(a1 * (Q1 - a1));
                    p += (w * poly16) / 64'sd4294967296;
                end
                m = Q1 - (p <= 0 ? Q1 : qdiv(a1, 64'(p)));
                cx = qdiv(st_frac[ord[b]], cden);
                sum += qdiv((m * cx) >> 16, x);
            end
            if (sum < Q1) cand = qdiv(a1, Q1 - sum);
            else if (sum == Q1) cand = Q1;
            else cand = 0;
            if (cand < best) best = cand;
        end
        return best > min_pl ? best : min_pl;
    endfunction

    // store one phase; returns 1 with the result when it closes the cell
    function automatic bit store_phase(phase_t ph, output cell_out_t res);
        if (n_stored < MAXN) begin
            st_diam[n_stored] = ph.diam;
            st_frac[n_stored] = ph.frac;
            st_lim[n_stored] = ph.lim;
            st_res[n_stored] = ph.res;
            n_stored++;
        end
        res.dil = 0;
        res.limit = 0;
        if (!ph.last) return 0;
        if (ph.total < mix_res) begin
            res.limit = min_pl[16:0];
            res.dil = 1;
        end else begin
            res.limit = 17'(mixture_limit(ph.total, ph.keep));
        end
        n_stored = 0;
        return 1;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch cell %0d %s: got %0d want %0d", cells_checked, what, got, want);
        errors++;
    endtask

    // result checking, results come as single-cycle strobes
    always @(posedge i_clk) begin
        cell_out_t e;
        if (i_rst_n && o_strobe) begin
            if (expected_cells.size() == 0) begin
                report_mismatch("unexpected result", o_packing_limit, 0);
            end else begin
                e = expected_cells.pop_front();
                if (o_packing_limit !== e.limit)
                    report_mismatch("packing_limit", o_packing_limit, e.limit);
                if (o_dilute !== e.dil) report_mismatch("dilute", o_dilute, e.dil);
            end
            cells_checked++;
        end
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge i_clk) begin
        if (o_strobe || (start && !busy) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 200000) begin
            $display("watchdog expired");
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic random_gap();
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    task automatic send_phase(phase_t ph);
        cell_out_t r;
        start <= 1'b1;
        i_diameter <= ph.diam;
        i_phase_fraction <= ph.frac;
        i_phase_max_fraction <= ph.lim;
        i_phase_residual <= ph.res;
        i_total_fraction <= ph.total;
        i_keep_order <= ph.keep;
        i_last_phase <= ph.last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // busy is low again at this edge; the phase is counted as transferred
        if (store_phase(ph, r)) expected_cells.push_back(r);
        phases_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_cells.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [16:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_MIX_RES: mix_res = val;
            CFG_MIN_PL: min_pl = val;
            CFG_RATIO_TOL: tol = val;
            default: ;
        endcase
    endtask

    function automatic phase_t rand_phase(bit last, bit wide);
        phase_t ph;
        case ($urandom_range(0, 3))
            0: ph.diam = $urandom_range(1, 1000);
            1: ph.diam = $urandom;
            default: ph.diam = $urandom_range(100, 400);
        endcase
        if (ph.diam == 0) ph.diam = 1;
        ph.frac = $urandom_range(0, 65536);
        ph.lim = $urandom_range(1, 65535);
        ph.res = wide ? $urandom_range(0, 65536) : $urandom_range(0, 2000);
        ph.total = $urandom_range(0, 65536);
        ph.keep = $urandom_range(0, 1);
        ph.last = last;
        return ph;
    endfunction

    // directed table: diam, frac, lim, res, total, keep, last
    phase_t dir_rows[] = '{
        '{32'd1, 17'd0, 16'd1, 17'd0, 17'd0, 1'b0, 1'b1},
        '{32'hFFFF_FFFF, 17'd65536, 16'd65535, 17'd65536, 17'd65536, 1'b1, 1'b1},
        '{32'd100, 17'd30000, 16'd40000, 17'd10, 17'd1, 1'b0, 1'b0},
        '{32'd50, 17'd20000, 16'd42000, 17'd10, 17'd60000, 1'b0, 1'b1},
        '{32'd50, 17'd20000, 16'd42000, 17'd10, 17'd1, 1'b0, 1'b0},
        '{32'd100, 17'd30000, 16'd40000, 17'd10, 17'd60000, 1'b1, 1'b1},
        '{32'd1, 17'd65536, 16'd60000, 17'd0, 17'd0, 1'b0, 1'b0},
        '{32'hFFFF_FFFF, 17'd65536, 16'd1, 17'd0, 17'd0, 1'b0, 1'b0},
        '{32'd700, 17'd5, 16'd30000, 17'd100, 17'd0, 1'b0, 1'b0},
        '{32'd1000, 17'd40000, 16'd50000, 17'd0, 17'd65536, 1'b0, 1'b1},
        '{32'd200, 17'd65536, 16'd1000, 17'd0, 17'd0, 1'b0, 1'b0},
        '{32'd210, 17'd65536, 16'd1000, 17'd0, 17'd100, 1'b0, 1'b1}
    };
    // typed-in results where obvious: dilute rows give the floor
    logic [17:0] dir_want[] = '{{1'b1, 17'd32768}, {1'b0, 17'd65535}, '1, '1,
                                '1, '1, '1, '1, '1, '1, '1, '1};

    initial begin
        cell_out_t r;
        int k, n;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows; a single present phase gives its own limit
        for (k = 0; k < dir_rows.size(); k++) begin
            send_phase(dir_rows[k]);
            if (dir_rows[k].last && dir_want[k] != '1 && expected_cells.size() != 0) begin
                r = expected_cells[$];
                if ({r.dil, r.limit} != dir_want[k])
                    report_mismatch("directed table", r.limit, dir_want[k][16:0]);
            end
        end
        // more phases than the store holds, last flag still closes the cell
        for (k = 0; k < 10; k++) send_phase(rand_phase(k == 9, 0));
        drain();

        // register settings, extremes included
        for (k = 0; k < 6; k++) begin
            case (k)
                0: begin write_reg(CFG_MIX_RES, 0); write_reg(CFG_MIN_PL, 0);
                         write_reg(CFG_RATIO_TOL, 0); end
                1: begin write_reg(CFG_MIX_RES, 65536); write_reg(CFG_MIN_PL, 65536);
                         write_reg(CFG_RATIO_TOL, 65536); end
                2: begin write_reg(CFG_MIX_RES, 1); write_reg(CFG_MIN_PL, 32768);
                         write_reg(CFG_RATIO_TOL, 0); end
                default: begin
                    write_reg(CFG_MIX_RES, $urandom_range(0, 20000));
                    write_reg(CFG_MIN_PL, $urandom_range(0, 65536));
                    write_reg(CFG_RATIO_TOL, $urandom_range(0, 8000));
                end
            endcase
            i_cfg_valid <= 1'b0;
            allow_gaps = (k != 5);
            repeat (35) begin
                n = $urandom_range(0, 9) == 0 ? $urandom_range(5, 9) : $urandom_range(1, 3);
                for (int j = 0; j < n; j++) begin
                    random_gap();
                    send_phase(rand_phase(j == n - 1, $urandom_range(0, 5) == 0));
                end
                // for k == 3, hold off until every cell result is back
                if (k == 3) drain();
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        $display("covered %0d phase transfers and %0d cell results", phases_sent, cells_checked);
        $display("across six register settings including both extremes");
        if (errors == 0 && expected_cells.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
hw/rtl/mpl_pkg.sv
hw/rtl/mpl_ram.sv
hw/rtl/mpl_div.sv
hw/rtl/mpl_dpath.sv
hw/rtl/mpl_ctrl.sv
hw/rtl/multiphase_packing_limit_unit.sv
hw/rtl/mpl_checker.sv
sim/tb_top.sv
